>>> hdl/ecpm_pkg.sv
// Shared types and codes for the elliptic-curve point unit.
// Used by ecpm_ctrl, ecpm_dp and the top level; no dependencies.
package ecpm_pkg;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_LATCH  = 4'd1;
  localparam op_t OP_ADD    = 4'd2;
  localparam op_t OP_SUB    = 4'd3;
  localparam op_t OP_COPY   = 4'd4;
  localparam op_t OP_MUL    = 4'd5;
  localparam op_t OP_RED    = 4'd6;
  localparam op_t OP_INV    = 4'd7;
  localparam op_t OP_LD_ADD = 4'd8;
  localparam op_t OP_LD_DBL = 4'd9;
  localparam op_t OP_LD_PR  = 4'd10;
  localparam op_t OP_SET_R1 = 4'd11;
  localparam op_t OP_SET_R2 = 4'd12;
  localparam op_t OP_SET_RP = 4'd13;

  typedef logic [3:0] sel_t;
  localparam sel_t SEL_PX  = 4'd0;
  localparam sel_t SEL_PY  = 4'd1;
  localparam sel_t SEL_QX  = 4'd2;
  localparam sel_t SEL_QY  = 4'd3;
  localparam sel_t SEL_RX  = 4'd4;
  localparam sel_t SEL_RY  = 4'd5;
  localparam sel_t SEL_X1  = 4'd6;
  localparam sel_t SEL_Y1  = 4'd7;
  localparam sel_t SEL_X2  = 4'd8;
  localparam sel_t SEL_Y2  = 4'd9;
  localparam sel_t SEL_N   = 4'd10;
  localparam sel_t SEL_D   = 4'd11;
  localparam sel_t SEL_T   = 4'd12;
  localparam sel_t SEL_LAM = 4'd13;
  localparam sel_t SEL_X3  = 4'd14;
  localparam sel_t SEL_A   = 4'd15;

  localparam logic REG_CURVE_A = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  localparam int CURVE_A_RST = 1;
  localparam int MODULUS_RST = 11;

  typedef struct packed {
    op_t  op;
    sel_t sa;
    sel_t sb;
    sel_t dst;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic eq_x;
    logic eq_y;
    logic neg_y;
    logic m_small;
  } stat_t;

endpackage

>>> hdl/ec_point_add_and_scalar_multiply.sv
// Top level of the elliptic-curve point add / scalar multiply unit.
// Instantiates ecpm_ctrl and ecpm_dp; types from ecpm_pkg.
//
// One item at a time: an item is taken when start is high and busy is low,
// and its result appears with a one-cycle done pulse, which the receiver
// must take then. The work runs through a bit-serial modular unit, which
// serves every multiply, every input reduction and every Euclid step of
// the inversion. An item costs five reductions, then per point operation
// three or four multiplies plus an inversion of up to about 1.5*FIELD_BITS
// Euclid steps. Mode 1 runs up to 2*(SCALAR_BITS-1) point operations plus
// a scan for the top scalar bit.
module ec_point_add_and_scalar_multiply import ecpm_pkg::*; #(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  output logic                   done,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [FIELD_BITS-1:0]  cfg_data,
  input  logic                   mode,
  input  logic [FIELD_BITS-1:0]  p_x,
  input  logic [FIELD_BITS-1:0]  p_y,
  input  logic                   p_inf,
  input  logic [FIELD_BITS-1:0]  q_x,
  input  logic [FIELD_BITS-1:0]  q_y,
  input  logic                   q_inf,
  input  logic [SCALAR_BITS-1:0] scalar,
  output logic [FIELD_BITS-1:0]  r_x,
  output logic [FIELD_BITS-1:0]  r_y,
  output logic                   r_inf
);

  cmd_t                  cmd;
  stat_t                 stat;
  logic [FIELD_BITS-1:0] res_x, res_y;

  ecpm_ctrl #(.SCALAR_BITS(SCALAR_BITS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .p_inf  (p_inf),
    .q_inf  (q_inf),
    .scalar (scalar),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .r_inf  (r_inf)
  );

  ecpm_dp #(.FIELD_BITS(FIELD_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .p_x       (p_x),
    .p_y       (p_y),
    .q_x       (q_x),
    .q_y       (q_y),
    .cmd       (cmd),
    .stat      (stat),
    .res_x     (res_x),
    .res_y     (res_y)
  );

  // point at infinity reads out with zero coordinates
  assign r_x = r_inf ? '0 : res_x;
  assign r_y = r_inf ? '0 : res_y;

endmodule

>>> hdl/ecpm_dp.sv
// Datapath: config registers, coordinate registers and a bit-serial
// modular multiply / divide / Euclid inverse unit. Depends on ecpm_pkg.
module ecpm_dp import ecpm_pkg::*; #(
  parameter int FIELD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data,
  input  logic [FIELD_BITS-1:0] p_x,
  input  logic [FIELD_BITS-1:0] p_y,
  input  logic [FIELD_BITS-1:0] q_x,
  input  logic [FIELD_BITS-1:0] q_y,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [FIELD_BITS-1:0] res_x,
  output logic [FIELD_BITS-1:0] res_y
);

  localparam int CW = $clog2(FIELD_BITS + 1);
  typedef logic [FIELD_BITS-1:0] fe_t;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_RUN  = 2'd1;
  localparam logic [1:0] U_ICHK = 2'd2;

  localparam logic [1:0] K_MUL = 2'd0;
  localparam logic [1:0] K_RED = 2'd1;
  localparam logic [1:0] K_DIV = 2'd2;

  fe_t cfg_a, cfg_m;
  fe_t px, py, qx, qy, rx, ry, x1, y1, x2, y2, nr, dr, tr, lam, x3, ar;

  logic [1:0]    uphase, kind;
  sel_t          udst;
  logic [CW-1:0] cnt;
  fe_t           acc, rem, dvd, mv, mu, divisor, r0, r1, t0, t1;

  fe_t             opa, opb, acc_n, rem_n, wr_data;
  logic [FIELD_BITS:0] rem_sh, rem_sub;
  logic            ge, qb, last, wr_en;
  sel_t            wr_sel;

  function automatic fe_t madd(input fe_t u, input fe_t v, input fe_t m);
    logic [FIELD_BITS:0] s, d;
    s = {1'b0, u} + {1'b0, v};
    d = s - {1'b0, m};
    return (s >= {1'b0, m}) ? d[FIELD_BITS-1:0] : s[FIELD_BITS-1:0];
  endfunction

  function automatic fe_t msub(input fe_t u, input fe_t v, input fe_t m);
    logic [FIELD_BITS:0] d;
    d = {1'b0, u} + {1'b0, m} - {1'b0, v};
    return (u >= v) ? u - v : d[FIELD_BITS-1:0];
  endfunction

  function automatic fe_t rd(input sel_t s);
    fe_t v;
    unique case (s)
      SEL_PX:  v = px;
      SEL_PY:  v = py;
      SEL_QX:  v = qx;
      SEL_QY:  v = qy;
      SEL_RX:  v = rx;
      SEL_RY:  v = ry;
      SEL_X1:  v = x1;
      SEL_Y1:  v = y1;
      SEL_X2:  v = x2;
      SEL_Y2:  v = y2;
      SEL_N:   v = nr;
      SEL_D:   v = dr;
      SEL_T:   v = tr;
      SEL_LAM: v = lam;
      SEL_X3:  v = x3;
      SEL_A:   v = ar;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_a <= FIELD_BITS'(CURVE_A_RST);
      cfg_m <= FIELD_BITS'(MODULUS_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURVE_A: cfg_a <= cfg_data;
        REG_MODULUS: cfg_m <= cfg_data;
      endcase
    end
  end

  always_comb begin
    opa = rd(cmd.sa);
    opb = rd(cmd.sb);
  end

  // one restoring-division step and one double-and-add step per cycle;
  // quotient bits (multiplier bits in a multiply) feed the accumulator so q*t1 mod m comes out with q
  always_comb begin
    rem_sh  = {rem, dvd[FIELD_BITS-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    ge      = rem_sh >= {1'b0, divisor};
    rem_n   = ge ? rem_sub[FIELD_BITS-1:0] : rem_sh[FIELD_BITS-1:0];
    qb      = (kind == K_MUL) ? mv[FIELD_BITS-1] : ge;
    acc_n   = madd(madd(acc, acc, cfg_m), qb ? mu : '0, cfg_m);
    last    = cnt == CW'(1);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = cmd.dst;
    wr_data = '0;
    if (uphase == U_RUN && last && kind != K_DIV) begin
      wr_en   = 1'b1;
      wr_sel  = udst;
      wr_data = (kind == K_MUL) ? acc_n : rem_n;
    end else if (uphase == U_ICHK && r1 == '0) begin
      wr_en   = 1'b1;
      wr_sel  = udst;
      wr_data = (r0 == fe_t'(1)) ? t0 : fe_t'(1);
    end else begin
      case (cmd.op)
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = madd(opa, opb, cfg_m);
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = msub(opa, opb, cfg_m);
        end
        OP_COPY: begin
          wr_en   = 1'b1;
          wr_data = opa;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_sel)
        SEL_PX:  px  <= wr_data;
        SEL_PY:  py  <= wr_data;
        SEL_QX:  qx  <= wr_data;
        SEL_QY:  qy  <= wr_data;
        SEL_RX:  rx  <= wr_data;
        SEL_RY:  ry  <= wr_data;
        SEL_X1:  x1  <= wr_data;
        SEL_Y1:  y1  <= wr_data;
        SEL_X2:  x2  <= wr_data;
        SEL_Y2:  y2  <= wr_data;
        SEL_N:   nr  <= wr_data;
        SEL_D:   dr  <= wr_data;
        SEL_T:   tr  <= wr_data;
        SEL_LAM: lam <= wr_data;
        SEL_X3:  x3  <= wr_data;
        SEL_A:   ar  <= wr_data;
      endcase
    end
    case (cmd.op)
      OP_LATCH: begin
        px <= p_x;
        py <= p_y;
        qx <= q_x;
        qy <= q_y;
        ar <= cfg_a;
      end
      OP_LD_ADD: begin
        x1 <= px;
        y1 <= py;
        x2 <= qx;
        y2 <= qy;
      end
      OP_LD_DBL: begin
        x1 <= rx;
        y1 <= ry;
        x2 <= rx;
        y2 <= ry;
      end
      OP_LD_PR: begin
        x1 <= px;
        y1 <= py;
        x2 <= rx;
        y2 <= ry;
      end
      OP_SET_R1: begin
        rx <= x1;
        ry <= y1;
      end
      OP_SET_R2: begin
        rx <= x2;
        ry <= y2;
      end
      OP_SET_RP: begin
        rx <= px;
        ry <= py;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uphase <= U_IDLE;
    end else begin
      case (uphase)
        U_IDLE: begin
          case (cmd.op)
            OP_MUL: begin
              mu     <= opa;
              mv     <= opb;
              acc    <= '0;
              cnt    <= CW'(FIELD_BITS);
              kind   <= K_MUL;
              udst   <= cmd.dst;
              uphase <= U_RUN;
            end
            OP_RED: begin
              dvd     <= opa;
              rem     <= '0;
              divisor <= cfg_m;
              cnt     <= CW'(FIELD_BITS);
              kind    <= K_RED;
              udst    <= cmd.dst;
              uphase  <= U_RUN;
            end
            OP_INV: begin
              r0     <= cfg_m;
              r1     <= opa;
              t0     <= '0;
              t1     <= fe_t'(1);
              udst   <= cmd.dst;
              uphase <= U_ICHK;
            end
            default: ;
          endcase
        end
        U_RUN: begin
          rem <= rem_n;
          acc <= acc_n;
          dvd <= dvd << 1;
          mv  <= mv << 1;
          cnt <= cnt - CW'(1);
          if (last) begin
            if (kind == K_DIV) begin
              r0     <= r1;
              r1     <= rem_n;
              t0     <= t1;
              t1     <= msub(t0, acc_n, cfg_m);
              uphase <= U_ICHK;
            end else begin
              uphase <= U_IDLE;
            end
          end
        end
        U_ICHK: begin
          if (r1 == '0) begin
            uphase <= U_IDLE;
          end else begin
            dvd     <= r0;
            divisor <= r1;
            rem     <= '0;
            acc     <= '0;
            mu      <= t1;
            cnt     <= CW'(FIELD_BITS);
            kind    <= K_DIV;
            uphase  <= U_RUN;
          end
        end
        default: uphase <= U_IDLE;
      endcase
    end
  end

  assign stat.idle    = uphase == U_IDLE;
  assign stat.eq_x    = x1 == x2;
  assign stat.eq_y    = y1 == y2;
  assign stat.neg_y   = y1 == msub('0, y2, cfg_m);
  assign stat.m_small = cfg_m < fe_t'(2);

  assign res_x = rx;
  assign res_y = ry;

endmodule

>>> hdl/ecpm_ctrl.sv
// Controller: sequences reductions, point additions and the scalar loop.
// Drives ecpm_dp through cmd_t / stat_t from ecpm_pkg.
module ecpm_ctrl import ecpm_pkg::*; #(
  parameter int SCALAR_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   mode,
  input  logic                   p_inf,
  input  logic                   q_inf,
  input  logic [SCALAR_BITS-1:0] scalar,
  input  stat_t                  stat,
  output cmd_t                   cmd,
  output logic                   busy,
  output logic                   done,
  output logic                   r_inf
);

  localparam int BW = $clog2(SCALAR_BITS + 1);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RA   = 5'd1;
  localparam logic [4:0] ST_RPX  = 5'd2;
  localparam logic [4:0] ST_RPY  = 5'd3;
  localparam logic [4:0] ST_RQX  = 5'd4;
  localparam logic [4:0] ST_RQY  = 5'd5;
  localparam logic [4:0] ST_DISP = 5'd6;
  localparam logic [4:0] ST_SCAN = 5'd7;
  localparam logic [4:0] ST_LOOP = 5'd8;
  localparam logic [4:0] ST_CHK  = 5'd9;
  localparam logic [4:0] ST_E1   = 5'd10;
  localparam logic [4:0] ST_E2   = 5'd11;
  localparam logic [4:0] ST_E3   = 5'd12;
  localparam logic [4:0] ST_E4   = 5'd13;
  localparam logic [4:0] ST_E5   = 5'd14;
  localparam logic [4:0] ST_N1   = 5'd15;
  localparam logic [4:0] ST_N2   = 5'd16;
  localparam logic [4:0] ST_INV  = 5'd17;
  localparam logic [4:0] ST_LAM  = 5'd18;
  localparam logic [4:0] ST_SQ   = 5'd19;
  localparam logic [4:0] ST_X3A  = 5'd20;
  localparam logic [4:0] ST_X3B  = 5'd21;
  localparam logic [4:0] ST_YA   = 5'd22;
  localparam logic [4:0] ST_YB   = 5'd23;
  localparam logic [4:0] ST_YC   = 5'd24;
  localparam logic [4:0] ST_XC   = 5'd25;
  localparam logic [4:0] ST_AEND = 5'd26;
  localparam logic [4:0] ST_OUT  = 5'd27;

  logic [4:0]             state, state_next;
  logic                   mode_q, mode_next;
  logic                   f1, f1_next, f2, f2_next;
  logic                   rinf, rinf_next, dbl, dbl_next;
  logic [SCALAR_BITS-1:0] k, k_next;
  logic [BW-1:0]          bits, bits_next;

  function automatic cmd_t mk(input op_t o, input sel_t a, input sel_t b, input sel_t d);
    cmd_t c;
    c.op  = o;
    c.sa  = a;
    c.sb  = b;
    c.dst = d;
    return c;
  endfunction

  // step: issue at most one datapath op when the serial unit is free, then advance
  always_comb begin
    state_next = state;
    mode_next  = mode_q;
    f1_next    = f1;
    f2_next    = f2;
    rinf_next  = rinf;
    dbl_next   = dbl;
    k_next     = k;
    bits_next  = bits;
    cmd        = mk(OP_NONE, SEL_PX, SEL_PX, SEL_PX);
    done       = 1'b0;
    case (state)
      ST_IDLE: if (start) begin
        cmd        = mk(OP_LATCH, SEL_PX, SEL_PX, SEL_PX);
        mode_next  = mode;
        f1_next    = p_inf;
        f2_next    = q_inf;
        k_next     = scalar;
        bits_next  = BW'(SCALAR_BITS - 1);
        dbl_next   = 1'b0;
        state_next = ST_RA;
      end
      ST_RA: if (stat.idle) begin
        cmd = mk(OP_RED, SEL_A, SEL_A, SEL_A);
        state_next = ST_RPX;
      end
      ST_RPX: if (stat.idle) begin
        cmd = mk(OP_RED, SEL_PX, SEL_PX, SEL_PX);
        state_next = ST_RPY;
      end
      ST_RPY: if (stat.idle) begin
        cmd = mk(OP_RED, SEL_PY, SEL_PY, SEL_PY);
        state_next = ST_RQX;
      end
      ST_RQX: if (stat.idle) begin
        cmd = mk(OP_RED, SEL_QX, SEL_QX, SEL_QX);
        state_next = ST_RQY;
      end
      ST_RQY: if (stat.idle) begin
        cmd = mk(OP_RED, SEL_QY, SEL_QY, SEL_QY);
        state_next = ST_DISP;
      end
      ST_DISP: if (stat.idle) begin
        if (stat.m_small) begin
          rinf_next  = 1'b1;
          state_next = ST_OUT;
        end else if (!mode_q) begin
          cmd = mk(OP_LD_ADD, SEL_PX, SEL_PX, SEL_PX);
          state_next = ST_CHK;
        end else if (k == '0 || f1) begin
          rinf_next  = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k[SCALAR_BITS-1]) begin
          cmd = mk(OP_SET_RP, SEL_PX, SEL_PX, SEL_PX);
          rinf_next  = 1'b0;
          state_next = ST_LOOP;
        end else begin
          k_next    = k << 1;
          bits_next = bits - BW'(1);
        end
      end
      ST_LOOP: begin
        if (bits == '0) begin
          state_next = ST_OUT;
        end else begin
          cmd = mk(OP_LD_DBL, SEL_PX, SEL_PX, SEL_PX);
          k_next     = k << 1;
          bits_next  = bits - BW'(1);
          f1_next    = rinf;
          f2_next    = rinf;
          dbl_next   = 1'b1;
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (f1) begin
          cmd = mk(OP_SET_R2, SEL_PX, SEL_PX, SEL_PX);
          rinf_next  = f2;
          state_next = ST_AEND;
        end else if (f2) begin
          cmd = mk(OP_SET_R1, SEL_PX, SEL_PX, SEL_PX);
          rinf_next  = 1'b0;
          state_next = ST_AEND;
        end else if (stat.eq_x && stat.neg_y) begin
          rinf_next  = 1'b1;
          state_next = ST_AEND;
        end else if (stat.eq_x && stat.eq_y) begin
          state_next = ST_E1;
        end else begin
          state_next = ST_N1;
        end
      end
      // tangent slope: (3x^2 + a) / 2y
      ST_E1: if (stat.idle) begin
        cmd = mk(OP_MUL, SEL_X1, SEL_X1, SEL_T);
        state_next = ST_E2;
      end
      ST_E2: if (stat.idle) begin
        cmd = mk(OP_ADD, SEL_T, SEL_T, SEL_N);
        state_next = ST_E3;
      end
      ST_E3: begin
        cmd = mk(OP_ADD, SEL_N, SEL_T, SEL_N);
        state_next = ST_E4;
      end
      ST_E4: begin
        cmd = mk(OP_ADD, SEL_N, SEL_A, SEL_N);
        state_next = ST_E5;
      end
      ST_E5: begin
        cmd = mk(OP_ADD, SEL_Y1, SEL_Y1, SEL_D);
        state_next = ST_INV;
      end
      // chord slope: (y2 - y1) / (x2 - x1)
      ST_N1: begin
        cmd = mk(OP_SUB, SEL_Y2, SEL_Y1, SEL_N);
        state_next = ST_N2;
      end
      ST_N2: begin
        cmd = mk(OP_SUB, SEL_X2, SEL_X1, SEL_D);
        state_next = ST_INV;
      end
      ST_INV: if (stat.idle) begin
        cmd = mk(OP_INV, SEL_D, SEL_D, SEL_D);
        state_next = ST_LAM;
      end
      ST_LAM: if (stat.idle) begin
        cmd = mk(OP_MUL, SEL_N, SEL_D, SEL_LAM);
        state_next = ST_SQ;
      end
      ST_SQ: if (stat.idle) begin
        cmd = mk(OP_MUL, SEL_LAM, SEL_LAM, SEL_T);
        state_next = ST_X3A;
      end
      ST_X3A: if (stat.idle) begin
        cmd = mk(OP_SUB, SEL_T, SEL_X1, SEL_T);
        state_next = ST_X3B;
      end
      ST_X3B: begin
        cmd = mk(OP_SUB, SEL_T, SEL_X2, SEL_X3);
        state_next = ST_YA;
      end
      ST_YA: begin
        cmd = mk(OP_SUB, SEL_X1, SEL_X3, SEL_T);
        state_next = ST_YB;
      end
      ST_YB: begin
        cmd = mk(OP_MUL, SEL_LAM, SEL_T, SEL_T);
        state_next = ST_YC;
      end
      ST_YC: if (stat.idle) begin
        cmd = mk(OP_SUB, SEL_T, SEL_Y1, SEL_RY);
        state_next = ST_XC;
      end
      ST_XC: begin
        cmd = mk(OP_COPY, SEL_X3, SEL_X3, SEL_RX);
        rinf_next  = 1'b0;
        state_next = ST_AEND;
      end
      ST_AEND: begin
        if (!mode_q) begin
          state_next = ST_OUT;
        end else if (dbl) begin
          dbl_next = 1'b0;
          if (k[SCALAR_BITS-1]) begin
            cmd = mk(OP_LD_PR, SEL_PX, SEL_PX, SEL_PX);
            f1_next    = 1'b0;
            f2_next    = rinf;
            state_next = ST_CHK;
          end else begin
            state_next = ST_LOOP;
          end
        end else begin
          state_next = ST_LOOP;
        end
      end
      ST_OUT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mode_q <= 1'b0;
      f1     <= 1'b0;
      f2     <= 1'b0;
      rinf   <= 1'b0;
      dbl    <= 1'b0;
      k      <= '0;
      bits   <= '0;
    end else begin
      state  <= state_next;
      mode_q <= mode_next;
      f1     <= f1_next;
      f2     <= f2_next;
      rinf   <= rinf_next;
      dbl    <= dbl_next;
      k      <= k_next;
      bits   <= bits_next;
    end
  end

  assign busy  = state != ST_IDLE;
  assign r_inf = rinf;

endmodule

>>> hdl/ecpm_check.sv
// Port-level checks for the elliptic-curve point unit, bound to the top.
// Depends on ec_point_add_and_scalar_multiply.
module ecpm_check #(
  parameter int FIELD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [FIELD_BITS-1:0] r_x,
  input logic [FIELD_BITS-1:0] r_y,
  input logic                  r_inf
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside an item");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("item not closed after its result");

  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && r_inf) |-> (r_x == '0 && r_y == '0))
    else $error("infinite result with nonzero coordinates");

endmodule

bind ec_point_add_and_scalar_multiply ecpm_check #(.FIELD_BITS(FIELD_BITS)) u_check (.*);
